FILE: design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// cond in this cycle implies expr in the next one
`define CHK_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
// cond implies expr in the same cycle
`define CHK_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`endif

FILE: design/c8ic_pkg.sv
package c8ic_pkg;

   localparam int ADDR_W          = 12;
   localparam int MEM_BYTES       = 4096;
   localparam int DISP_ROWS       = 32;
   localparam int DISP_COLS       = 64;
   localparam int ROW_W           = 5;
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic [15:0]       SEED_RESET = 16'hACE1;
   localparam logic [15:0]       LFSR_TAPS  = 16'hB400;
   localparam logic [ADDR_W-1:0] PC_RESET   = 12'h200;
   localparam logic [ADDR_W-1:0] FONT_BASE  = 12'h050;
   localparam logic [ADDR_W-1:0] FONT_END   = 12'h0A0;
   localparam logic [ADDR_W-1:0] ADDR_LAST  = 12'hFFF;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_EXEC = 2'd1;
   localparam logic [1:0] CMD_ROW  = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_KEY_WAIT = 2'd1;
   localparam logic [1:0] ST_FAULT    = 2'd2;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   localparam logic [3:0] GRP_SYS      = 4'h0;
   localparam logic [3:0] GRP_JUMP     = 4'h1;
   localparam logic [3:0] GRP_CALL     = 4'h2;
   localparam logic [3:0] GRP_SEQ_IMM  = 4'h3;
   localparam logic [3:0] GRP_SNE_IMM  = 4'h4;
   localparam logic [3:0] GRP_SEQ_REG  = 4'h5;
   localparam logic [3:0] GRP_SET_IMM  = 4'h6;
   localparam logic [3:0] GRP_ADD_IMM  = 4'h7;
   localparam logic [3:0] GRP_ALU      = 4'h8;
   localparam logic [3:0] GRP_SNE_REG  = 4'h9;
   localparam logic [3:0] GRP_SET_IDX  = 4'hA;
   localparam logic [3:0] GRP_JUMP_V0  = 4'hB;
   localparam logic [3:0] GRP_RANDOM   = 4'hC;
   localparam logic [3:0] GRP_DRAW     = 4'hD;
   localparam logic [3:0] GRP_KEY      = 4'hE;
   localparam logic [3:0] GRP_MISC     = 4'hF;

   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   localparam logic [7:0] KEY_DOWN = 8'h9E;
   localparam logic [7:0] KEY_UP   = 8'hA1;

   localparam logic [7:0] FX_GET_DELAY = 8'h07;
   localparam logic [7:0] FX_WAIT_KEY  = 8'h0A;
   localparam logic [7:0] FX_SET_DELAY = 8'h15;
   localparam logic [7:0] FX_SET_SOUND = 8'h18;
   localparam logic [7:0] FX_ADD_IDX   = 8'h1E;
   localparam logic [7:0] FX_FONT      = 8'h29;
   localparam logic [7:0] FX_BCD       = 8'h33;
   localparam logic [7:0] FX_STORE     = 8'h55;
   localparam logic [7:0] FX_LOAD      = 8'h65;

   localparam logic [3:0] REG_FLAG = 4'hF;

   localparam logic [7:0] FONT_GLYPHS [0:79] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   typedef struct packed {
      logic capture_req;
      logic clear_step;
      logic mem_wr_load;
      logic row_rd;
      logic row_cap;
      logic fetch_hi;
      logic fetch_lo;
      logic reg_x;
      logic reg_y;
      logic cap_y;
      logic exec;
      logic ret_rd;
      logic ret_cap;
      logic draw_rd;
      logic draw_wr;
      logic bcd_wr;
      logic store_rd;
      logic store_wr;
      logic load_rd;
      logic load_wr;
      logic flag_wr;
      logic tick;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic ret_ok;
      logic draw;
      logic draw_go;
      logic draw_more;
      logic bcd;
      logic store;
      logic load;
      logic flag;
      logic loop_last;
   } dp_status_type;

endpackage

FILE: design/c8ic_ram.sv
module c8ic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/c8ic_ctrl.sv
`include "assert_macros.svh"

module c8ic_ctrl import c8ic_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_command,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   typedef enum logic [22:0] {
      S_CLEAR    = 23'd1 << 0,
      S_IDLE     = 23'd1 << 1,
      S_MEM_WR   = 23'd1 << 2,
      S_ROW_RD   = 23'd1 << 3,
      S_ROW_CAP  = 23'd1 << 4,
      S_FETCH_HI = 23'd1 << 5,
      S_FETCH_LO = 23'd1 << 6,
      S_REG_X    = 23'd1 << 7,
      S_REG_Y    = 23'd1 << 8,
      S_CAP_Y    = 23'd1 << 9,
      S_EXEC     = 23'd1 << 10,
      S_RET_RD   = 23'd1 << 11,
      S_RET_CAP  = 23'd1 << 12,
      S_DRAW_RD  = 23'd1 << 13,
      S_DRAW_WR  = 23'd1 << 14,
      S_BCD      = 23'd1 << 15,
      S_STORE_RD = 23'd1 << 16,
      S_STORE_WR = 23'd1 << 17,
      S_LOAD_RD  = 23'd1 << 18,
      S_LOAD_WR  = 23'd1 << 19,
      S_FLAG     = 23'd1 << 20,
      S_TICK     = 23'd1 << 21,
      S_RESULT   = 23'd1 << 22
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               unique case (req_command)
                  CMD_LOAD: state_in = S_MEM_WR;
                  CMD_EXEC: state_in = S_FETCH_HI;
                  CMD_ROW:  state_in = S_ROW_RD;
                  CMD_NONE: state_in = S_RESULT;
               endcase
            end
         end
         S_MEM_WR:   state_in = S_RESULT;
         S_ROW_RD:   state_in = S_ROW_CAP;
         S_ROW_CAP:  state_in = S_RESULT;
         S_FETCH_HI: state_in = S_FETCH_LO;
         S_FETCH_LO: state_in = S_REG_X;
         S_REG_X:    state_in = S_REG_Y;
         S_REG_Y:    state_in = S_CAP_Y;
         S_CAP_Y:    state_in = S_EXEC;
         S_EXEC: begin
            priority if (status.ret_ok) state_in = S_RET_RD;
            else if (status.draw) state_in = status.draw_go ? S_DRAW_RD : S_FLAG;
            else if (status.bcd) state_in = S_BCD;
            else if (status.store) state_in = S_STORE_RD;
            else if (status.load) state_in = S_LOAD_RD;
            else if (status.flag) state_in = S_FLAG;
            else state_in = S_TICK;
         end
         S_RET_RD:   state_in = S_RET_CAP;
         S_RET_CAP:  state_in = S_TICK;
         S_DRAW_RD:  state_in = S_DRAW_WR;
         S_DRAW_WR:  state_in = status.draw_more ? S_DRAW_RD : S_FLAG;
         S_BCD:      state_in = status.loop_last ? S_TICK : S_BCD;
         S_STORE_RD: state_in = S_STORE_WR;
         S_STORE_WR: state_in = status.loop_last ? S_TICK : S_STORE_RD;
         S_LOAD_RD:  state_in = S_LOAD_WR;
         S_LOAD_WR:  state_in = status.loop_last ? S_TICK : S_LOAD_RD;
         S_FLAG:     state_in = S_TICK;
         S_TICK:     state_in = S_RESULT;
         S_RESULT:   state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.capture_req = (state_ff == S_IDLE) && start;
      cmd.clear_step  = state_ff == S_CLEAR;
      cmd.mem_wr_load = state_ff == S_MEM_WR;
      cmd.row_rd      = state_ff == S_ROW_RD;
      cmd.row_cap     = state_ff == S_ROW_CAP;
      cmd.fetch_hi    = state_ff == S_FETCH_HI;
      cmd.fetch_lo    = state_ff == S_FETCH_LO;
      cmd.reg_x       = state_ff == S_REG_X;
      cmd.reg_y       = state_ff == S_REG_Y;
      cmd.cap_y       = state_ff == S_CAP_Y;
      cmd.exec        = state_ff == S_EXEC;
      cmd.ret_rd      = state_ff == S_RET_RD;
      cmd.ret_cap     = state_ff == S_RET_CAP;
      cmd.draw_rd     = state_ff == S_DRAW_RD;
      cmd.draw_wr     = state_ff == S_DRAW_WR;
      cmd.bcd_wr      = state_ff == S_BCD;
      cmd.store_rd    = state_ff == S_STORE_RD;
      cmd.store_wr    = state_ff == S_STORE_WR;
      cmd.load_rd     = state_ff == S_LOAD_RD;
      cmd.load_wr     = state_ff == S_LOAD_WR;
      cmd.flag_wr     = state_ff == S_FLAG;
      cmd.tick        = state_ff == S_TICK;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_RESULT;

   `CHK_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe && !busy)
   `CHK_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `CHK_NEXT(a_clear_holds, clock, reset, (state_ff == S_CLEAR) && !status.clear_last,
             state_ff == S_CLEAR)

endmodule

FILE: design/c8ic_datapath.sv
module c8ic_datapath import c8ic_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [11:0]   req_load_address,
   input  logic [7:0]    req_load_byte,
   input  logic [15:0]   req_keys_down,
   input  logic [4:0]    req_row_select,
   input  logic          csr_write_enable,
   input  logic [15:0]   csr_write_data,
   output logic [11:0]   rsp_program_counter,
   output logic [1:0]    rsp_status,
   output logic [63:0]   rsp_row_pixels,
   output logic          rsp_sound_on
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int SA_W = $clog2(STACK_DEPTH);

   logic [ADDR_W-1:0] laddr_ff;
   logic [7:0]        lbyte_ff;
   logic [15:0]       keys_ff;
   logic [ROW_W-1:0]  rsel_ff;
   logic [15:0]       op_ff;
   logic [7:0]        vx_ff, vy_ff;
   logic [ADDR_W-1:0] pc_ff, index_ff;
   logic [SP_W-1:0]   sp_ff;
   logic [7:0]        delay_ff, sound_ff;
   logic [15:0]       lfsr_ff, seed_ff;
   logic [1:0]        status_ff;
   logic [63:0]       row_ff;
   logic              flag_ff;
   logic [3:0]        cnt_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [15:0]       vvalid_ff;
   logic [DISP_ROWS-1:0] fvalid_ff;
   logic              vhit_ff, fhit_ff;

   logic [3:0] grp, xr, yr, nr;
   logic [7:0] nn;
   logic [ADDR_W-1:0] nnn, pc_plus1, pc_plus2, pc_plus4, idx_cnt;
   logic [ADDR_W-1:0] pc_exec, idx_val;
   logic [1:0] st_exec;
   logic vx_we, idx_we, delay_we, sound_we, push, frame_clear, flag_val;
   logic [7:0] vx_val, key_first;
   logic [8:0] sum9;
   logic [15:0] lfsr_next;
   logic key_pressed;
   logic [5:0] col;
   logic [ROW_W-1:0] draw_row;
   logic [5:0] row_next;
   logic [4:0] cnt_next;
   logic [SP_W-1:0] sp_minus1;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata, mem_rdata, font_byte;
   logic              vreg_we;
   logic [3:0]        vreg_waddr, vreg_raddr;
   logic [7:0]        vreg_wdata, vreg_rdata, vreg_out;
   logic              frame_we;
   logic [ROW_W-1:0]  frame_raddr;
   logic [63:0]       frame_wdata, frame_rdata, frame_out, sprite_mask;
   logic [11:0]       stack_rdata;
   logic [7:0]        bcd_hund, bcd_rem, bcd_tens, bcd_ones, bcd_digit;
   logic [14:0]       tens_prod;
   logic [6:0]        font_idx;

   assign grp = op_ff[15:12];
   assign xr  = op_ff[11:8];
   assign yr  = op_ff[7:4];
   assign nr  = op_ff[3:0];
   assign nn  = op_ff[7:0];
   assign nnn = op_ff[11:0];

   assign pc_plus1  = pc_ff + 12'd1;
   assign pc_plus2  = pc_ff + 12'd2;
   assign pc_plus4  = pc_ff + 12'd4;
   assign idx_cnt   = index_ff + {8'd0, cnt_ff};
   assign sum9      = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign lfsr_next = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
   assign key_pressed = (vx_ff[7:4] == 4'd0) && keys_ff[vx_ff[3:0]];
   assign sp_minus1 = sp_ff - {{(SP_W-1){1'b0}}, 1'b1};

   assign col      = vx_ff[5:0];
   assign draw_row = vy_ff[ROW_W-1:0] + {1'b0, cnt_ff};
   assign row_next = {1'b0, vy_ff[ROW_W-1:0]} + {2'b0, cnt_ff} + 6'd1;
   assign cnt_next = {1'b0, cnt_ff} + 5'd1;

   always_comb begin
      key_first = 8'd0;
      for (int k = 15; k >= 0; k--) begin
         if (keys_ff[k]) key_first = 8'(k);
      end
   end

   // decimal digits of vx
   always_comb begin
      if (vx_ff >= 8'd200) bcd_hund = 8'd2;
      else if (vx_ff >= 8'd100) bcd_hund = 8'd1;
      else bcd_hund = 8'd0;
      bcd_rem   = vx_ff - 8'((bcd_hund * 8'd100));
      tens_prod = {8'd0, bcd_rem[6:0]} * 15'd205;
      bcd_tens  = {4'd0, tens_prod[14:11]};
      bcd_ones  = bcd_rem - 8'((bcd_tens * 8'd10));
      unique case (cnt_ff[1:0])
         2'd0:    bcd_digit = bcd_hund;
         2'd1:    bcd_digit = bcd_tens;
         default: bcd_digit = bcd_ones;
      endcase
   end

   always_comb begin
      pc_exec     = pc_plus2;
      st_exec     = ST_DONE;
      vx_we       = 1'b0;
      vx_val      = vx_ff;
      flag_val    = 1'b0;
      idx_we      = 1'b0;
      idx_val     = index_ff;
      delay_we    = 1'b0;
      sound_we    = 1'b0;
      push        = 1'b0;
      frame_clear = 1'b0;
      unique case (grp)
         GRP_SYS: begin
            if (op_ff == OP_CLS) frame_clear = 1'b1;
            if (op_ff == OP_RET && sp_ff == '0) st_exec = ST_FAULT;
         end
         GRP_JUMP: pc_exec = nnn;
         GRP_CALL: begin
            if (sp_ff >= SP_W'(STACK_DEPTH)) begin
               st_exec = ST_FAULT;
            end else begin
               push    = 1'b1;
               pc_exec = nnn;
            end
         end
         GRP_SEQ_IMM: if (vx_ff == nn) pc_exec = pc_plus4;
         GRP_SNE_IMM: if (vx_ff != nn) pc_exec = pc_plus4;
         GRP_SEQ_REG: if (vx_ff == vy_ff) pc_exec = pc_plus4;
         GRP_SNE_REG: if (vx_ff != vy_ff) pc_exec = pc_plus4;
         GRP_SET_IMM: begin
            vx_we  = 1'b1;
            vx_val = nn;
         end
         GRP_ADD_IMM: begin
            vx_we  = 1'b1;
            vx_val = vx_ff + nn;
         end
         GRP_ALU: begin
            vx_we = 1'b1;
            unique case (nr)
               ALU_MOV: vx_val = vy_ff;
               ALU_OR:  vx_val = vx_ff | vy_ff;
               ALU_AND: vx_val = vx_ff & vy_ff;
               ALU_XOR: vx_val = vx_ff ^ vy_ff;
               ALU_ADD: begin
                  vx_val   = sum9[7:0];
                  flag_val = sum9[8];
               end
               ALU_SUB: begin
                  vx_val   = vx_ff - vy_ff;
                  flag_val = vx_ff >= vy_ff;
               end
               ALU_SHR: begin
                  vx_val   = {1'b0, vx_ff[7:1]};
                  flag_val = vx_ff[0];
               end
               ALU_SUBN: begin
                  vx_val   = vy_ff - vx_ff;
                  flag_val = vy_ff >= vx_ff;
               end
               ALU_SHL: begin
                  vx_val   = {vx_ff[6:0], 1'b0};
                  flag_val = vx_ff[7];
               end
               default: vx_we = 1'b0;
            endcase
         end
         GRP_SET_IDX: begin
            idx_we  = 1'b1;
            idx_val = nnn;
         end
         // vx holds v0 for this group
         GRP_JUMP_V0: pc_exec = nnn + {4'd0, vx_ff};
         GRP_RANDOM: begin
            vx_we  = 1'b1;
            vx_val = lfsr_next[7:0] & nn;
         end
         GRP_DRAW: flag_val = 1'b0;
         GRP_KEY: begin
            if ((nn == KEY_DOWN && key_pressed) || (nn == KEY_UP && !key_pressed))
               pc_exec = pc_plus4;
         end
         GRP_MISC: begin
            unique case (nn)
               FX_GET_DELAY: begin
                  vx_we  = 1'b1;
                  vx_val = delay_ff;
               end
               FX_WAIT_KEY: begin
                  if (keys_ff == 16'd0) begin
                     pc_exec = pc_ff;
                     st_exec = ST_KEY_WAIT;
                  end else begin
                     vx_we  = 1'b1;
                     vx_val = key_first;
                  end
               end
               FX_SET_DELAY: delay_we = 1'b1;
               FX_SET_SOUND: sound_we = 1'b1;
               FX_ADD_IDX: begin
                  idx_we  = 1'b1;
                  idx_val = index_ff + {4'd0, vx_ff};
               end
               FX_FONT: begin
                  idx_we  = 1'b1;
                  idx_val = FONT_BASE + {2'd0, vx_ff, 2'd0} + {4'd0, vx_ff};
               end
               default: idx_we = 1'b0;
            endcase
         end
      endcase
   end

   always_comb begin
      status.clear_last = clr_ff == ADDR_LAST;
      status.ret_ok     = (op_ff == OP_RET) && (sp_ff != '0);
      status.draw       = grp == GRP_DRAW;
      status.draw_go    = nr != 4'd0;
      status.draw_more  = (cnt_next < {1'b0, nr}) && !row_next[5];
      status.bcd        = (grp == GRP_MISC) && (nn == FX_BCD);
      status.store      = (grp == GRP_MISC) && (nn == FX_STORE);
      status.load       = (grp == GRP_MISC) && (nn == FX_LOAD);
      status.flag       = (grp == GRP_ALU) && (nr == ALU_ADD || nr == ALU_SUB ||
                          nr == ALU_SHR || nr == ALU_SUBN || nr == ALU_SHL);
      status.loop_last  = status.bcd ? (cnt_ff == 4'd2) : (cnt_ff == xr);
   end

   // main memory ports
   assign font_idx  = 7'(clr_ff - FONT_BASE);
   assign font_byte = (clr_ff >= FONT_BASE && clr_ff < FONT_END) ? FONT_GLYPHS[font_idx] : 8'd0;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = font_byte;
      priority if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.mem_wr_load) begin
         mem_we    = 1'b1;
         mem_waddr = laddr_ff;
         mem_wdata = lbyte_ff;
      end else if (cmd.bcd_wr) begin
         mem_we    = 1'b1;
         mem_waddr = idx_cnt;
         mem_wdata = bcd_digit;
      end else if (cmd.store_wr) begin
         mem_we    = 1'b1;
         mem_waddr = idx_cnt;
         mem_wdata = vreg_out;
      end
      priority if (cmd.fetch_lo) mem_raddr = pc_plus1;
      else if (cmd.draw_rd || cmd.load_rd) mem_raddr = idx_cnt;
      else mem_raddr = pc_ff;
   end

   // register file ports
   always_comb begin
      vreg_we    = 1'b0;
      vreg_waddr = xr;
      vreg_wdata = vx_val;
      priority if (cmd.flag_wr) begin
         vreg_we    = 1'b1;
         vreg_waddr = REG_FLAG;
         vreg_wdata = {7'd0, flag_ff};
      end else if (cmd.load_wr) begin
         vreg_we    = 1'b1;
         vreg_waddr = cnt_ff;
         vreg_wdata = mem_rdata;
      end else if (cmd.exec) begin
         vreg_we = vx_we;
      end
      priority if (cmd.reg_x) vreg_raddr = (op_ff[15:12] == GRP_JUMP_V0) ? 4'd0 : op_ff[11:8];
      else if (cmd.store_rd) vreg_raddr = cnt_ff;
      else vreg_raddr = yr;
   end

   assign vreg_out    = vhit_ff ? vreg_rdata : 8'd0;
   assign frame_out   = fhit_ff ? frame_rdata : 64'd0;
   assign sprite_mask = {mem_rdata, 56'd0} >> col;
   assign frame_wdata = frame_out ^ sprite_mask;
   assign frame_we    = cmd.draw_wr;
   assign frame_raddr = cmd.row_rd ? rsel_ff : draw_row;

   c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rdata)
   );

   c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
      .clock(clock), .we(vreg_we), .waddr(vreg_waddr), .wdata(vreg_wdata),
      .raddr(vreg_raddr), .rdata(vreg_rdata)
   );

   c8ic_ram #(.WIDTH(DISP_COLS), .DEPTH(DISP_ROWS)) u_frame (
      .clock(clock), .we(frame_we), .waddr(draw_row), .wdata(frame_wdata),
      .raddr(frame_raddr), .rdata(frame_rdata)
   );

   c8ic_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(cmd.exec && push), .waddr(sp_ff[SA_W-1:0]), .wdata(pc_plus2),
      .raddr(sp_minus1[SA_W-1:0]), .rdata(stack_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= PC_RESET;
         index_ff  <= '0;
         sp_ff     <= '0;
         delay_ff  <= '0;
         sound_ff  <= '0;
         lfsr_ff   <= SEED_RESET;
         seed_ff   <= SEED_RESET;
         clr_ff    <= '0;
         cnt_ff    <= '0;
         flag_ff   <= 1'b0;
         vvalid_ff <= '0;
         fvalid_ff <= '0;
      end else begin
         if (csr_write_enable) seed_ff <= csr_write_data;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 12'd1;
            if (clr_ff == '0) lfsr_ff <= seed_ff;
         end
         if (cmd.exec) begin
            pc_ff  <= pc_exec;
            cnt_ff <= '0;
            flag_ff <= flag_val;
            if (idx_we) index_ff <= idx_val;
            if (push) sp_ff <= sp_ff + {{(SP_W-1){1'b0}}, 1'b1};
            if (grp == GRP_RANDOM) lfsr_ff <= lfsr_next;
            if (frame_clear) fvalid_ff <= '0;
         end
         if (cmd.ret_cap) begin
            pc_ff <= stack_rdata;
            sp_ff <= sp_minus1;
         end
         if (cmd.draw_wr) begin
            flag_ff <= flag_ff | (|(frame_out & sprite_mask));
            fvalid_ff[draw_row] <= 1'b1;
         end
         if (cmd.draw_wr || cmd.bcd_wr || cmd.store_wr || cmd.load_wr) begin
            cnt_ff <= cnt_next[3:0];
         end
         if (vreg_we) vvalid_ff[vreg_waddr] <= 1'b1;
         if (cmd.exec && delay_we) delay_ff <= vx_ff;
         else if (cmd.tick && delay_ff != 8'd0) delay_ff <= delay_ff - 8'd1;
         if (cmd.exec && sound_we) sound_ff <= vx_ff;
         else if (cmd.tick && sound_ff != 8'd0) sound_ff <= sound_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      vhit_ff <= vvalid_ff[vreg_raddr];
      fhit_ff <= fvalid_ff[frame_raddr];
      if (cmd.capture_req) begin
         laddr_ff  <= req_load_address;
         lbyte_ff  <= req_load_byte;
         keys_ff   <= req_keys_down;
         rsel_ff   <= req_row_select;
         status_ff <= ST_DONE;
         row_ff    <= '0;
      end
      if (cmd.fetch_lo) op_ff[15:8] <= mem_rdata;
      if (cmd.reg_x) op_ff[7:0] <= mem_rdata;
      if (cmd.reg_y) vx_ff <= vreg_out;
      if (cmd.cap_y) vy_ff <= vreg_out;
      if (cmd.exec) status_ff <= st_exec;
      if (cmd.row_cap) row_ff <= frame_out;
   end

   assign rsp_program_counter = pc_ff;
   assign rsp_status          = status_ff;
   assign rsp_row_pixels      = row_ff;
   assign rsp_sound_on        = sound_ff != 8'd0;

endmodule

FILE: design/chip8_instruction_core.sv
// channel   ports                                  handshake
// request   req_command .. req_row_select          start high while busy low
// response  rsp_program_counter .. rsp_sound_on    rsp_strobe, one cycle
// csr       csr_write_data                         csr_write_enable
//
// load writes one byte, row read captures a frame row, unused command just strobes
// execute adds a read and a write per sprite row, a step for the collision flag, a
// read and a write per block store or load byte, a write per bcd digit, a step for an
// alu flag and a read and a capture for a return, each memory having one read port
// after reset a clearing pass writes the font into memory and zeroes the rest, busy stays high
// results cannot be stalled; the next request is taken the cycle after the strobe
module chip8_instruction_core import c8ic_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [11:0] req_load_address,
   input  logic [7:0]  req_load_byte,
   input  logic [15:0] req_keys_down,
   input  logic [4:0]  req_row_select,
   output logic        rsp_strobe,
   output logic [11:0] rsp_program_counter,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_row_pixels,
   output logic        rsp_sound_on,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   c8ic_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_command(req_command),
      .status(status), .cmd(cmd), .busy(busy), .rsp_strobe(rsp_strobe)
   );

   c8ic_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_load_address(req_load_address), .req_load_byte(req_load_byte),
      .req_keys_down(req_keys_down), .req_row_select(req_row_select),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_program_counter(rsp_program_counter), .rsp_status(rsp_status),
      .rsp_row_pixels(rsp_row_pixels), .rsp_sound_on(rsp_sound_on)
   );

endmodule
